// ----- rtl/core/pckm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pckm_pkg
// Shared types and constants for the color key matcher: beat layouts,
// register indexes, mode codes and register reset values.
// ---------------------------------------------------------------------------
package pckm_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WEIGHT_W   = 17;
  localparam int unsigned LAYOUT_W   = 21;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PIPE_DEPTH = 5;

  typedef struct packed {
    logic [WORD_W-1:0] pixel;
    logic [WORD_W-1:0] other_pixel;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_pixel;
    logic              matched;
  } out_beat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE           = 3'd0,
    CFG_KEY_COLOR      = 3'd1,
    CFG_REPLACE_COLOR  = 3'd2,
    CFG_THRESHOLD      = 3'd3,
    CFG_WEIGHT_RED     = 3'd4,
    CFG_WEIGHT_GREEN   = 3'd5,
    CFG_WEIGHT_BLUE    = 3'd6,
    CFG_CHANNEL_LAYOUT = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_REPLACE = 2'd0,
    MODE_MASK    = 2'd1,
    MODE_COMPARE = 2'd2
  } mode_t;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = 17'd19595;
  localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = 17'd38470;
  localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = 17'd7471;
  localparam logic [LAYOUT_W-1:0] LAYOUT_RST       = 21'd1835280;
  localparam logic [WEIGHT_W-1:0] THRESH_ONE       = 17'h10000;

endpackage
`default_nettype wire

// ----- rtl/core/pixel_color_key_matcher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pixel_color_key_matcher
// Per-pixel color key match: replace, mask extract or two-pixel compare.
// ---------------------------------------------------------------------------
// One result beat per input beat, in order. The datapath is a five-stage
// pipeline (channel extract and difference, square, weight multiply, sum,
// compare and select). An accepted pixel moves through the stage 1 to 4
// registers into the output register; a new pixel is taken every cycle unless
// a stalled output has backed up to the input, the registered multiplier
// stages setting that rate. Empty stages are filled while the output is
// stalled. Registers must be written by the user only while no beat is in
// flight; the block itself does not enforce this. The threshold limit is
// rebuilt via t255_r and lim_r after a write, ahead of any pixel reaching stage 5.
module pixel_color_key_matcher #(
  parameter int unsigned PIXEL_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire pckm_pkg::in_beat_t                   in_data,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      pckm_pkg::out_beat_t                  out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [pckm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pckm_pkg::WORD_W-1:0]          cfg_data
);
  import pckm_pkg::*;

  localparam logic [WORD_W-1:0] PIX_MASK = WORD_W'((64'd1 << PIXEL_BITS) - 64'd1);

  // configuration registers
  mode_t                mode_r;
  logic [WORD_W-1:0]    key_r;
  logic [WORD_W-1:0]    repl_r;
  logic [WEIGHT_W-1:0]  thresh_r;
  logic [WEIGHT_W-1:0]  wr_r;
  logic [WEIGHT_W-1:0]  wg_r;
  logic [WEIGHT_W-1:0]  wb_r;
  logic [LAYOUT_W-1:0]  layout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_REPLACE;
      key_r    <= '0;
      repl_r   <= '0;
      thresh_r <= '0;
      wr_r     <= WEIGHT_RED_RST;
      wg_r     <= WEIGHT_GREEN_RST;
      wb_r     <= WEIGHT_BLUE_RST;
      layout_r <= LAYOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:           mode_r   <= mode_t'(cfg_data[1:0]);
        CFG_KEY_COLOR:      key_r    <= cfg_data;
        CFG_REPLACE_COLOR:  repl_r   <= cfg_data;
        CFG_THRESHOLD:      thresh_r <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_RED:     wr_r     <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_GREEN:   wg_r     <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_BLUE:    wb_r     <= cfg_data[WEIGHT_W-1:0];
        CFG_CHANNEL_LAYOUT: layout_r <= cfg_data[LAYOUT_W-1:0];
      endcase
    end
  end

  logic [4:0] sh_red, sh_green, sh_blue, sh_alpha;
  assign sh_red   = layout_r[4:0];
  assign sh_green = layout_r[9:5];
  assign sh_blue  = layout_r[14:10];
  assign sh_alpha = layout_r[19:15];

  // limit = (sat(threshold) * 255)^2, rebuilt from the registers every cycle
  logic [WEIGHT_W-1:0] tsat;
  logic [23:0]         t255_r;
  logic [47:0]         lim_r;

  assign tsat = thresh_r[16] ? THRESH_ONE : thresh_r;

  always_ff @(posedge clk) begin
    t255_r <= 24'(({8'd0, tsat} << 8) - {8'd0, tsat});
    lim_r  <= 48'(t255_r) * 48'(t255_r);
  end

  // pipeline handshake: a stage loads when it is empty or the next one loads
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || !out_stall;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // stage 1: pick the compared pair, extract channels, absolute differences
  function automatic logic [7:0] chan(input logic [WORD_W-1:0] word,
                                      input logic [4:0] sh);
    logic [WORD_W-1:0] s;
    s = word >> sh;
    return s[7:0];
  endfunction

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [WORD_W-1:0] px_m, oth_m, key_m, cmp_a, cmp_b;

  assign px_m  = in_data.pixel & PIX_MASK;
  assign oth_m = in_data.other_pixel & PIX_MASK;
  assign key_m = key_r & PIX_MASK;

  always_comb begin
    if (mode_r == MODE_COMPARE) begin
      cmp_a = px_m;
      cmp_b = oth_m;
    end else begin
      cmp_a = key_m;
      cmp_b = px_m;
    end
  end

  typedef struct packed {
    logic [WORD_W-1:0] px;
    logic              eq;
  } side_t;

  side_t      s1_side_r, s2_side_r, s3_side_r, s4_side_r;
  logic [7:0] s1_dr_r, s1_dg_r, s1_db_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_side_r.px <= px_m;
      s1_side_r.eq <= (cmp_a == cmp_b);
      s1_dr_r      <= absdiff(chan(cmp_a, sh_red),   chan(cmp_b, sh_red));
      s1_dg_r      <= absdiff(chan(cmp_a, sh_green), chan(cmp_b, sh_green));
      s1_db_r      <= absdiff(chan(cmp_a, sh_blue),  chan(cmp_b, sh_blue));
    end
  end

  // stage 2: squares
  logic [15:0] s2_qr_r, s2_qg_r, s2_qb_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_side_r <= s1_side_r;
      s2_qr_r   <= 16'(s1_dr_r) * 16'(s1_dr_r);
      s2_qg_r   <= 16'(s1_dg_r) * 16'(s1_dg_r);
      s2_qb_r   <= 16'(s1_db_r) * 16'(s1_db_r);
    end
  end

  // stage 3: weight products
  logic [32:0] s3_pr_r, s3_pg_r, s3_pb_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_side_r <= s2_side_r;
      s3_pr_r   <= 33'(wr_r) * 33'(s2_qr_r);
      s3_pg_r   <= 33'(wg_r) * 33'(s2_qg_r);
      s3_pb_r   <= 33'(wb_r) * 33'(s2_qb_r);
    end
  end

  // stage 4: weighted sum
  logic [34:0] s4_sum_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_side_r <= s3_side_r;
      s4_sum_r  <= 35'(s3_pr_r) + 35'(s3_pg_r) + 35'(s3_pb_r);
    end
  end

  // stage 5: compare against the limit and pick the written-back word
  logic [WORD_W-1:0] alpha_w, white_w, black_w, res_px;
  logic              hit;

  always_comb begin
    alpha_w = layout_r[20] ? (WORD_W'(8'hFF) << sh_alpha) : '0;
    white_w = ((WORD_W'(8'hFF) << sh_red) | (WORD_W'(8'hFF) << sh_green) |
               (WORD_W'(8'hFF) << sh_blue) | alpha_w) & PIX_MASK;
    black_w = alpha_w & PIX_MASK;

    if (thresh_r == '0) begin
      hit = s4_side_r.eq;
    end else begin
      hit = ({s4_sum_r, 16'd0} <= {3'd0, lim_r});
    end

    unique case (mode_r)
      MODE_REPLACE: res_px = hit ? (repl_r & PIX_MASK) : s4_side_r.px;
      MODE_MASK:    res_px = hit ? white_w : black_w;
      MODE_COMPARE: res_px = hit ? white_w : black_w;
      default: begin
        // unused mode: pass the pixel through, never matched
        res_px = s4_side_r.px;
        hit    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_data.result_pixel <= res_px;
      out_data.matched      <= hit;
    end
  end

  assign out_valid = v5_r;

endmodule
`default_nettype wire

// ----- rtl/core/pckm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pckm_checker
// Port-level checks on the color key matcher: output hold under stall and
// in-flight beat accounting against the pipeline depth.
// ---------------------------------------------------------------------------
module pckm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire pckm_pkg::out_beat_t out_data
);
  import pckm_pkg::*;

  logic       in_acc, out_acc;
  logic [2:0] cnt_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // beats accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= 3'(cnt_r + {2'd0, in_acc} - {2'd0, out_acc});
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat dropped or changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 3'd0)
    else $error("output beat without a pending input beat");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(PIPE_DEPTH))
    else $error("more beats in flight than pipeline stages");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < 3'(PIPE_DEPTH) |-> !in_stall)
    else $error("input stalled while a pipeline stage is empty");

endmodule

bind pixel_color_key_matcher pckm_checker u_pckm_checker (.*);
`default_nettype wire

// ----- tb/tb_pixel_color_key_matcher.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pixel_color_key_matcher
// Self-checking bench for the color key matcher. Each accepted pixel beat is
// run through a local integer model of the key match (exact or weighted
// distance rule, replace / mask / compare / pass-through) and the predicted
// beat is queued. Result beats are checked field by field in order. Directed
// corner cases come first, then a backpressure run and randomized phases
// under fresh register settings, some with random sender gaps or receiver stalls.
// ---------------------------------------------------------------------------
module tb_pixel_color_key_matcher;
  import pckm_pkg::*;

  localparam int unsigned PIXEL_BITS      = 32;
  localparam logic [31:0] PIX_MASK        = 32'hFFFF_FFFF >> (32 - PIXEL_BITS);
  localparam logic [1:0]  MODE_UNUSED     = 2'd3;
  localparam int          WATCHDOG_LIMIT  = 4000;
  localparam int          LONG_HOLD       = 300;
  localparam int          RANDOM_PHASES   = 8;
  localparam int          ITEMS_PER_PHASE = 70;
  localparam int          PRESSURE_ITEMS  = 120;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_index = CFG_MODE;
  logic [31:0] cfg_data = '0;

  // Local copy of the register file
  logic [1:0]  m_mode   = MODE_REPLACE;
  logic [31:0] m_key    = '0;
  logic [31:0] m_repl   = '0;
  logic [16:0] m_thresh = '0;
  logic [16:0] m_wr     = WEIGHT_RED_RST;
  logic [16:0] m_wg     = WEIGHT_GREEN_RST;
  logic [16:0] m_wb     = WEIGHT_BLUE_RST;
  logic [20:0] m_layout = LAYOUT_RST;

  out_beat_t awaited_pixels[$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        gap_max = 0;
  int        burst_left = 0;
  int        stall_pct = 0;
  bit        long_hold_pending = 1'b0;

  pixel_color_key_matcher #(.PIXEL_BITS(PIXEL_BITS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic logic [20:0] make_layout(int rs, int gs, int bs, int as, bit alpha);
    return {alpha, 5'(as), 5'(bs), 5'(gs), 5'(rs)};
  endfunction

  function automatic logic [63:0] channel_sq_diff(logic [31:0] a, logic [31:0] b,
                                                  logic [4:0] sh);
    logic [31:0] wa, wb;
    logic [7:0]  ca, cb;
    wa = a >> sh;
    wb = b >> sh;
    ca = wa[7:0];
    cb = wb[7:0];
    if (ca > cb) return {56'd0, ca - cb} * {56'd0, ca - cb};
    else return {56'd0, cb - ca} * {56'd0, cb - ca};
  endfunction

  function automatic logic within_distance(logic [31:0] a, logic [31:0] b);
    logic [63:0] t, lim, s;
    if (m_thresh == '0) return a == b;
    t   = (m_thresh > THRESH_ONE) ? 64'(THRESH_ONE) : 64'(m_thresh);
    lim = (t * 64'd255) * (t * 64'd255);
    s   = 64'(m_wr) * channel_sq_diff(a, b, m_layout[4:0])
        + 64'(m_wg) * channel_sq_diff(a, b, m_layout[9:5])
        + 64'(m_wb) * channel_sq_diff(a, b, m_layout[14:10]);
    return (s << 16) <= lim;
  endfunction

  function automatic logic [31:0] mask_word(logic hit);
    logic [31:0] alpha, white;
    alpha = m_layout[20] ? (32'd255 << m_layout[19:15]) : 32'd0;
    white = (32'd255 << m_layout[4:0]) | (32'd255 << m_layout[9:5])
          | (32'd255 << m_layout[14:10]) | alpha;
    return (hit ? white : alpha) & PIX_MASK;
  endfunction

  function automatic out_beat_t color_key_outcome(in_beat_t beat);
    out_beat_t   r;
    logic [31:0] px, oth, key;
    px  = beat.pixel & PIX_MASK;
    oth = beat.other_pixel & PIX_MASK;
    key = m_key & PIX_MASK;
    r.matched      = 1'b0;
    r.result_pixel = px;
    case (m_mode)
      MODE_REPLACE: begin
        r.matched      = within_distance(key, px);
        r.result_pixel = r.matched ? (m_repl & PIX_MASK) : px;
      end
      MODE_MASK: begin
        r.matched      = within_distance(key, px);
        r.result_pixel = mask_word(r.matched);
      end
      MODE_COMPARE: begin
        r.matched      = within_distance(px, oth);
        r.result_pixel = mask_word(r.matched);
      end
      default: ;
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------- drivers
  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:           m_mode   = value[1:0];
      CFG_KEY_COLOR:      m_key    = value;
      CFG_REPLACE_COLOR:  m_repl   = value;
      CFG_THRESHOLD:      m_thresh = value[16:0];
      CFG_WEIGHT_RED:     m_wr     = value[16:0];
      CFG_WEIGHT_GREEN:   m_wg     = value[16:0];
      CFG_WEIGHT_BLUE:    m_wb     = value[16:0];
      CFG_CHANNEL_LAYOUT: m_layout = value[20:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [31:0] pixel, logic [31:0] other);
    in_beat_t beat;
    int       gap;
    beat.pixel       = pixel;
    beat.other_pixel = other;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    awaited_pixels.push_back(color_key_outcome(beat));
    if (burst_left > 0) begin
      burst_left--;
    end else if (gap_max > 0) begin
      // pick the next burst length, then close the burst with a gap
      burst_left = $urandom_range(0, 15);
      gap = $urandom_range(1, gap_max);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  function automatic logic [31:0] nudge_pixel(logic [31:0] w);
    logic [31:0] v;
    v = w;
    if ($urandom_range(0, 1)) v = v ^ (32'($urandom_range(0, 15)) << m_layout[4:0]);
    if ($urandom_range(0, 1)) v = v ^ (32'($urandom_range(0, 15)) << m_layout[9:5]);
    if ($urandom_range(0, 1)) v = v ^ (32'($urandom_range(0, 15)) << m_layout[14:10]);
    if ($urandom_range(0, 3) == 0) v = v ^ (32'd1 << $urandom_range(0, 31));
    return v;
  endfunction

  // Mostly near-key pixels (or near-equal pairs in compare mode)
  task automatic send_random_pixel();
    logic [31:0] base, px, oth;
    int          pick;
    pick = $urandom_range(0, 99);
    base = (m_mode == MODE_COMPARE) ? $urandom() : m_key;
    px   = (pick < 25) ? base : (pick < 65) ? nudge_pixel(base) : $urandom();
    oth  = $urandom();
    if (m_mode == MODE_COMPARE) begin
      px  = $urandom();
      oth = (pick < 25) ? px : (pick < 65) ? nudge_pixel(px) : $urandom();
    end
    send_pixel(px, oth);
  endtask

  task automatic program_random_setup();
    int          wr, wg;
    logic [16:0] thr;
    logic [20:0] lay;
    write_reg(CFG_MODE, ($urandom_range(0, 9) == 0) ? 32'(MODE_UNUSED)
                                                     : 32'($urandom_range(0, 2)));
    write_reg(CFG_KEY_COLOR, $urandom());
    write_reg(CFG_REPLACE_COLOR, $urandom());
    case ($urandom_range(0, 5))
      0: thr = '0;
      1: thr = 17'($urandom_range(1, 300));
      2: thr = 17'($urandom_range(1, 4000));
      3: thr = 17'($urandom_range(1, 65536));
      4: thr = THRESH_ONE;
      default: thr = 17'($urandom_range(65537, 131071));
    endcase
    write_reg(CFG_THRESHOLD, 32'(thr));
    if ($urandom_range(0, 3) == 0) begin
      // weights that may exceed one, used as given
      write_reg(CFG_WEIGHT_RED, $urandom_range(0, 131071));
      write_reg(CFG_WEIGHT_GREEN, $urandom_range(0, 131071));
      write_reg(CFG_WEIGHT_BLUE, $urandom_range(0, 131071));
    end else begin
      wr = $urandom_range(0, 65536);
      wg = $urandom_range(0, 65536 - wr);
      write_reg(CFG_WEIGHT_RED, 32'(wr));
      write_reg(CFG_WEIGHT_GREEN, 32'(wg));
      write_reg(CFG_WEIGHT_BLUE, 32'(65536 - wr - wg));
    end
    case ($urandom_range(0, 7))
      0: lay = LAYOUT_RST;
      1: lay = make_layout(0, 8, 16, 24, 1'b1);
      2: lay = make_layout(24, 16, 8, 0, 1'b1);
      3: lay = make_layout(16, 8, 0, 0, 1'b0);
      default: lay = 21'($urandom_range(0, 21'h1F_FFFF));
    endcase
    write_reg(CFG_CHANNEL_LAYOUT, 32'(lay));
  endtask

  // --------------------------------------------------------------- tests
  task automatic test_reset_values();
    send_pixel(32'h0000_0000, 32'h0000_0000);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(32'h0000_0001, 32'h0000_0000);
    drain_pipeline();
  endtask

  task automatic test_replace_exact();
    write_reg(CFG_KEY_COLOR, 32'h80FF_0001);
    write_reg(CFG_REPLACE_COLOR, 32'hDEAD_BEEF);
    send_pixel(32'h80FF_0001, 32'h0000_0000);
    send_pixel(32'h00FF_0001, 32'hFFFF_FFFF);
    send_pixel(32'h0000_0000, 32'h0000_0000);
    drain_pipeline();
  endtask

  task automatic test_distance_rule();
    write_reg(CFG_KEY_COLOR, 32'h0000_0000);
    write_reg(CFG_REPLACE_COLOR, 32'hA5A5_A5A5);
    // full-scale threshold: the largest difference lands exactly on the limit
    write_reg(CFG_THRESHOLD, 32'(THRESH_ONE));
    send_pixel(32'h00FF_FFFF, 32'h0000_0000);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    drain_pipeline();
    write_reg(CFG_THRESHOLD, 32'h0001_FFFF);
    send_pixel(32'h00FF_FFFF, 32'h0000_0000);
    drain_pipeline();
    // smallest threshold: alpha alone differs, then one step of blue
    write_reg(CFG_THRESHOLD, 32'd1);
    send_pixel(32'hFF00_0000, 32'h0000_0000);
    send_pixel(32'h0000_0001, 32'h0000_0000);
    drain_pipeline();
    write_reg(CFG_THRESHOLD, 32'(THRESH_ONE));
    write_reg(CFG_WEIGHT_RED, 32'h0001_FFFF);
    write_reg(CFG_WEIGHT_GREEN, 32'h0001_FFFF);
    write_reg(CFG_WEIGHT_BLUE, 32'h0001_FFFF);
    send_pixel(32'h00FF_FFFF, 32'h0000_0000);
    send_pixel(32'h0010_1010, 32'h0000_0000);
    drain_pipeline();
    write_reg(CFG_WEIGHT_RED, 32'd0);
    write_reg(CFG_WEIGHT_GREEN, 32'd0);
    write_reg(CFG_WEIGHT_BLUE, 32'd0);
    send_pixel(32'h00FF_FFFF, 32'hFFFF_FFFF);
    drain_pipeline();
  endtask

  task automatic test_mask_mode();
    write_reg(CFG_MODE, 32'(MODE_MASK));
    write_reg(CFG_THRESHOLD, 32'd0);
    write_reg(CFG_KEY_COLOR, 32'h1122_3344);
    send_pixel(32'h1122_3344, 32'h0000_0000);
    send_pixel(32'h1122_3345, 32'h0000_0000);
    drain_pipeline();
    write_reg(CFG_CHANNEL_LAYOUT, 32'(make_layout(16, 8, 0, 24, 1'b0)));
    send_pixel(32'h1122_3344, 32'h0000_0000);
    send_pixel(32'h0000_0000, 32'h0000_0000);
    drain_pipeline();
    // red at the top bit: most of the channel falls off the word
    write_reg(CFG_CHANNEL_LAYOUT, 32'(make_layout(31, 8, 0, 28, 1'b1)));
    send_pixel(32'h1122_3344, 32'h0000_0000);
    send_pixel(32'h0000_0000, 32'h0000_0000);
    drain_pipeline();
  endtask

  task automatic test_compare_mode();
    write_reg(CFG_MODE, 32'(MODE_COMPARE));
    write_reg(CFG_CHANNEL_LAYOUT, 32'(LAYOUT_RST));
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(32'h1234_5678, 32'h1234_5679);
    drain_pipeline();
    write_reg(CFG_THRESHOLD, 32'd1000);
    write_reg(CFG_WEIGHT_RED, 32'(WEIGHT_RED_RST));
    write_reg(CFG_WEIGHT_GREEN, 32'(WEIGHT_GREEN_RST));
    write_reg(CFG_WEIGHT_BLUE, 32'(WEIGHT_BLUE_RST));
    send_pixel(32'h0080_8080, 32'h0081_8181);
    drain_pipeline();
  endtask

  task automatic test_unused_mode();
    write_reg(CFG_MODE, 32'(MODE_UNUSED));
    send_pixel(32'hCAFE_F00D, 32'hCAFE_F00D);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
    drain_pipeline();
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_backpressure();
    program_random_setup();
    gap_max   = 0;
    stall_pct = 0;
    long_hold_pending = 1'b1;
    repeat (PRESSURE_ITEMS) send_random_pixel();
    drain_pipeline();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_random_setup();
      gap_max   = (phase % 2 == 1) ? $urandom_range(1, 8) : 0;
      stall_pct = (phase % 4 >= 2) ? $urandom_range(10, 60) : 0;
      repeat (ITEMS_PER_PHASE) send_random_pixel();
      drain_pipeline();
    end
  endtask

  // ------------------------------------------------------------ receiver
  initial begin : receiver_pattern
    int run;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        run = $urandom_range(1, 5);
        repeat (run) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_pixels.size() == 0) begin
        $display("%0t: result beat with nothing expected: got %h", $time, out_data);
        errors++;
      end else begin
        want = awaited_pixels.pop_front();
        if (out_data.result_pixel !== want.result_pixel) begin
          $display("%0t: result_pixel mismatch: expected %h, got %h", $time,
                   want.result_pixel, out_data.result_pixel);
          errors++;
        end
        if (out_data.matched !== want.matched) begin
          $display("%0t: matched mismatch: expected %b, got %b", $time,
                   want.matched, out_data.matched);
          errors++;
        end
      end
    end
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, awaited_pixels.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_replace_exact();
    test_distance_rule();
    test_mask_mode();
    test_compare_mode();
    test_unused_mode();
    test_backpressure();
    test_random_traffic();
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (awaited_pixels.size() != 0) errors++;
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
